### sv/detection_row_decoder_macros.svh
// assertion helpers, clock clk and active-low reset rst_n
`ifndef DETECTION_ROW_DECODER_MACROS_SVH
`define DETECTION_ROW_DECODER_MACROS_SVH

// same-cycle implication
`define DRD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/drd_pkg.sv
`default_nettype none
package drd_pkg;

    localparam int MAX_CLASSES  = 128;
    localparam int VALUE_W      = 32;
    localparam int THR_W        = 17;
    localparam int SCALE_W      = 16;
    localparam int POS_W        = 8;
    localparam int ROW_W        = 16;
    localparam int CLASS_W      = 7;
    localparam int BOX_W        = 24;
    localparam int BOX_FIELDS   = 4;
    localparam int FRAC_W       = 16;
    localparam int SCALE_FRAC_W = 8;
    localparam int NUM_W        = VALUE_W + 2;
    localparam int PROD_W       = NUM_W + SCALE_W + 1;
    localparam int QUEUE_DEPTH  = 2;

    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = THR_W;

    localparam logic [CFG_INDEX_W-1:0] REG_LAYOUT_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLASS_COUNT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCORE_THR      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CONFIDENCE_THR = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_X_SCALE        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_SCALE        = 3'd5;

    localparam logic [POS_W-1:0] FIRST_CLASS_BOX = POS_W'(BOX_FIELDS);
    localparam logic [POS_W-1:0] FIRST_CLASS_OBJ = POS_W'(BOX_FIELDS + 1);

    localparam logic signed [PROD_W-1:0] BOX_HI = PROD_W'((2 ** (BOX_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] BOX_LO = -BOX_HI - PROD_W'(1);

    typedef struct packed {
        logic                      layout_mode;
        logic [POS_W-1:0]          class_count;
        logic [THR_W-1:0]          score_threshold;
        logic [THR_W-1:0]          confidence_threshold;
        logic [SCALE_W-1:0]        x_scale;
        logic [SCALE_W-1:0]        y_scale;
    } drd_cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0]          row_number;
        logic [CLASS_W-1:0]        class_index;
        logic signed [VALUE_W-1:0] score;
        logic signed [VALUE_W-1:0] x;
        logic signed [VALUE_W-1:0] y;
        logic signed [VALUE_W-1:0] w;
        logic signed [VALUE_W-1:0] h;
    } drd_det_t;

    // truncate toward zero after dropping frac bits, then clamp to the box range
    function automatic logic signed [BOX_W-1:0] drd_trunc_sat(
        input logic signed [PROD_W-1:0] p,
        input logic                     half
    );
        logic signed [PROD_W-1:0] q;
        logic                     rem;
        if (half)
        begin
            q   = p >>> (FRAC_W + SCALE_FRAC_W + 1);
            rem = |p[FRAC_W+SCALE_FRAC_W:0];
        end
        else
        begin
            q   = p >>> (FRAC_W + SCALE_FRAC_W);
            rem = |p[FRAC_W+SCALE_FRAC_W-1:0];
        end
        if (p[PROD_W-1] && rem)
        begin
            q = q + PROD_W'(1);
        end
        if (q > BOX_HI)
        begin
            q = BOX_HI;
        end
        else if (q < BOX_LO)
        begin
            q = BOX_LO;
        end
        return q[BOX_W-1:0];
    endfunction

endpackage
`default_nettype wire

### sv/detection_row_decoder.sv
// detection_row_decoder: decodes a detector's output stream into boxes
// input channel (in_valid/in_ready, value, frame_start): one Q16.16 element
// per transfer; a row is x, y, w, h, objectness in layout 1, then the class
// scores; frame_start on the first element of a frame clears row position
// and row number
// output channel (out_valid/out_ready): one detection for each row whose best
// class score passes the thresholds, with row number, class, score and box
// configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
// ready, one register write per transfer, to be used while the block is idle
// throughput: one element per cycle while the queue is not full, limited by
// the per-element compare in the front stage; the box multiplies run at most
// once per row; a detection is written to the queue on the transfer of the
// last element of its row, then passes through the multiply stage and the
// output register
// a two-entry queue sits between front and back; if the receiver stalls the
// queue fills and in_ready drops until a detection is taken
// reset clears row position, row number, pipeline valids and queue, and
// loads the register defaults
`default_nettype none
module detection_row_decoder (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [drd_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  wire logic [drd_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire logic signed [drd_pkg::VALUE_W-1:0]       value,
    input  wire logic                                     frame_start,
    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output logic [drd_pkg::ROW_W-1:0]                     row_number,
    output logic [drd_pkg::CLASS_W-1:0]                   class_index,
    output logic signed [drd_pkg::VALUE_W-1:0]            score,
    output logic signed [drd_pkg::BOX_W-1:0]              box_left,
    output logic signed [drd_pkg::BOX_W-1:0]              box_top,
    output logic signed [drd_pkg::BOX_W-1:0]              box_width,
    output logic signed [drd_pkg::BOX_W-1:0]              box_height
);
    import drd_pkg::*;

    drd_cfg_t cfg_reg;
    logic     queue_full;
    logic     push;
    drd_det_t push_data;
    logic     pop;
    logic     head_valid;
    drd_det_t head_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.layout_mode          <= 1'b0;
            cfg_reg.class_count          <= POS_W'(80);
            cfg_reg.score_threshold      <= THR_W'(29491);
            cfg_reg.confidence_threshold <= THR_W'(16384);
            cfg_reg.x_scale              <= SCALE_W'(256);
            cfg_reg.y_scale              <= SCALE_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LAYOUT_MODE:    cfg_reg.layout_mode          <= cfg_data[0];
                REG_CLASS_COUNT:    cfg_reg.class_count          <= cfg_data[POS_W-1:0];
                REG_SCORE_THR:      cfg_reg.score_threshold      <= cfg_data[THR_W-1:0];
                REG_CONFIDENCE_THR: cfg_reg.confidence_threshold <= cfg_data[THR_W-1:0];
                REG_X_SCALE:        cfg_reg.x_scale              <= cfg_data[SCALE_W-1:0];
                REG_Y_SCALE:        cfg_reg.y_scale              <= cfg_data[SCALE_W-1:0];
                default:            ;
            endcase
        end
    end

    drd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .frame_start (frame_start),
        .queue_full  (queue_full),
        .push        (push),
        .push_data   (push_data)
    );

    drd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    drd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_valid  (head_valid),
        .head_data   (head_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_number  (row_number),
        .class_index (class_index),
        .score       (score),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_width   (box_width),
        .box_height  (box_height)
    );

endmodule
`default_nettype wire

### sv/drd_front.sv
`default_nettype none
module drd_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire drd_pkg::drd_cfg_t                  cfg,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [drd_pkg::VALUE_W-1:0] value,
    input  wire logic                               frame_start,
    input  wire logic                               queue_full,
    output logic                                    push,
    output drd_pkg::drd_det_t                       push_data
);
    import drd_pkg::*;

    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic signed [VALUE_W-1:0] box_reg [BOX_FIELDS];
    logic signed [VALUE_W-1:0] obj_reg;
    logic signed [VALUE_W-1:0] best_reg, best_next;
    logic [CLASS_W-1:0]        cls_reg, cls_next;

    logic                      accept;
    logic [POS_W-1:0]          cnt;
    logic [POS_W-1:0]          first;
    logic [POS_W-1:0]          last;
    logic [POS_W-1:0]          p;
    logic [ROW_W-1:0]          row;
    logic [POS_W-1:0]          k_raw;
    logic [POS_W-1:0]          k;
    logic                      is_class;
    logic                      take;
    logic                      row_end;
    logic                      v_gt, b_gt, obj_ok, pass;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (cfg.class_count == '0)
        begin
            cnt = POS_W'(1);
        end
        else if (cfg.class_count > POS_W'(MAX_CLASSES))
        begin
            cnt = POS_W'(MAX_CLASSES);
        end
        else
        begin
            cnt = cfg.class_count;
        end
    end

    assign first    = cfg.layout_mode ? FIRST_CLASS_OBJ : FIRST_CLASS_BOX;
    assign last     = first + cnt - POS_W'(1);
    assign p        = frame_start ? '0 : pos_reg;
    assign row      = frame_start ? '0 : row_reg;
    assign k_raw    = p - first;
    assign k        = (k_raw > cnt - POS_W'(1)) ? cnt - POS_W'(1) : k_raw;
    assign is_class = p >= first;
    assign take     = is_class && ((p == first) || (value > best_reg));
    assign row_end  = p >= last;

    assign best_next = take ? value : best_reg;
    assign cls_next  = take ? k[CLASS_W-1:0] : cls_reg;

    // thresholds are non-negative, compare one bit wider
    assign v_gt   = $signed({value[VALUE_W-1], value})
                    > $signed({{(VALUE_W+1-THR_W){1'b0}}, cfg.score_threshold});
    assign b_gt   = $signed({best_reg[VALUE_W-1], best_reg})
                    > $signed({{(VALUE_W+1-THR_W){1'b0}}, cfg.score_threshold});
    assign obj_ok = $signed({obj_reg[VALUE_W-1], obj_reg})
                    >= $signed({{(VALUE_W+1-THR_W){1'b0}}, cfg.confidence_threshold});
    assign pass   = (take ? v_gt : b_gt) && (!cfg.layout_mode || obj_ok);

    assign pos_next = row_end ? '0 : p + POS_W'(1);
    assign row_next = row_end ? row + ROW_W'(1) : row;

    assign push = accept && row_end && pass;

    always_comb
    begin
        push_data.row_number  = row;
        push_data.class_index = cls_next;
        push_data.score       = cfg.layout_mode ? obj_reg : best_next;
        push_data.x           = box_reg[0];
        push_data.y           = box_reg[1];
        push_data.w           = box_reg[2];
        push_data.h           = box_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < BOX_FIELDS; i++)
            begin
                box_reg[i] <= '0;
            end
            obj_reg  <= '0;
            best_reg <= '0;
            cls_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            row_reg <= row_next;
            if (p < FIRST_CLASS_BOX)
            begin
                box_reg[p[1:0]] <= value;
            end
            else if (p < first)
            begin
                obj_reg <= value;
            end
            else
            begin
                best_reg <= best_next;
                cls_reg  <= cls_next;
            end
        end
    end

endmodule
`default_nettype wire

### sv/drd_queue.sv
`default_nettype none
`include "detection_row_decoder_macros.svh"
module drd_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire drd_pkg::drd_det_t push_data,
    input  wire logic              pop,
    output logic                   full,
    output logic                   head_valid,
    output drd_pkg::drd_det_t      head_data
);
    import drd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    drd_det_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    `DRD_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
    `DRD_ASSERT_IMPLY(a_no_push_full, push, !full, "detection pushed into full queue")
    `DRD_ASSERT_NEXT(a_push_count, do_push && !do_pop, count_reg == $past(count_reg) + CNT_W'(1), "count did not grow on push")
    `DRD_ASSERT_NEXT(a_pop_count, do_pop && !do_push, count_reg == $past(count_reg) - CNT_W'(1), "count did not shrink on pop")

endmodule
`default_nettype wire

### sv/drd_back.sv
`default_nettype none
module drd_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire drd_pkg::drd_cfg_t                   cfg,
    input  wire logic                                head_valid,
    input  wire drd_pkg::drd_det_t                   head_data,
    output logic                                     pop,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [drd_pkg::ROW_W-1:0]                row_number,
    output logic [drd_pkg::CLASS_W-1:0]              class_index,
    output logic signed [drd_pkg::VALUE_W-1:0]       score,
    output logic signed [drd_pkg::BOX_W-1:0]         box_left,
    output logic signed [drd_pkg::BOX_W-1:0]         box_top,
    output logic signed [drd_pkg::BOX_W-1:0]         box_width,
    output logic signed [drd_pkg::BOX_W-1:0]         box_height
);
    import drd_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0]          row_number;
        logic [CLASS_W-1:0]        class_index;
        logic signed [VALUE_W-1:0] score;
        logic signed [PROD_W-1:0]  p_left;
        logic signed [PROD_W-1:0]  p_top;
        logic signed [PROD_W-1:0]  p_width;
        logic signed [PROD_W-1:0]  p_height;
    } drd_prod_t;

    logic                       mul_valid_reg, mul_valid_next;
    drd_prod_t                  mul_reg, mul_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       en_mul, en_out;
    logic signed [NUM_W-1:0]    n_left, n_top, n_width, n_height;
    logic signed [SCALE_W:0]    xs, ys;

    assign en_out = !out_valid_reg || out_ready;
    assign en_mul = !mul_valid_reg || en_out;
    assign pop    = head_valid && en_mul;

    // 2x - w gives the doubled left edge
    assign n_left   = {head_data.x[VALUE_W-1], head_data.x, 1'b0}
                      - {{2{head_data.w[VALUE_W-1]}}, head_data.w};
    assign n_top    = {head_data.y[VALUE_W-1], head_data.y, 1'b0}
                      - {{2{head_data.h[VALUE_W-1]}}, head_data.h};
    assign n_width  = {{2{head_data.w[VALUE_W-1]}}, head_data.w};
    assign n_height = {{2{head_data.h[VALUE_W-1]}}, head_data.h};
    assign xs       = {1'b0, cfg.x_scale};
    assign ys       = {1'b0, cfg.y_scale};

    always_comb
    begin
        mul_next.row_number  = head_data.row_number;
        mul_next.class_index = head_data.class_index;
        mul_next.score       = head_data.score;
        mul_next.p_left      = PROD_W'(n_left) * PROD_W'(xs);
        mul_next.p_top       = PROD_W'(n_top) * PROD_W'(ys);
        mul_next.p_width     = PROD_W'(n_width) * PROD_W'(xs);
        mul_next.p_height    = PROD_W'(n_height) * PROD_W'(ys);
    end

    assign mul_valid_next = en_mul ? head_valid : mul_valid_reg;
    assign out_valid_next = en_out ? mul_valid_reg : out_valid_reg;
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en_mul && head_valid)
        begin
            mul_reg <= mul_next;
        end
        if (en_out && mul_valid_reg)
        begin
            row_number  <= mul_reg.row_number;
            class_index <= mul_reg.class_index;
            score       <= mul_reg.score;
            box_left    <= drd_trunc_sat(mul_reg.p_left, 1'b1);
            box_top     <= drd_trunc_sat(mul_reg.p_top, 1'b1);
            box_width   <= drd_trunc_sat(mul_reg.p_width, 1'b0);
            box_height  <= drd_trunc_sat(mul_reg.p_height, 1'b0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### tb/detection_row_decoder_tb.sv
`default_nettype none
module detection_row_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import drd_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      frame_start;
    } element_t;

    typedef struct {
        logic [ROW_W-1:0]          row;
        logic [CLASS_W-1:0]        cls;
        logic signed [VALUE_W-1:0] score;
        logic signed [BOX_W-1:0]   left;
        logic signed [BOX_W-1:0]   top_edge;
        logic signed [BOX_W-1:0]   width;
        logic signed [BOX_W-1:0]   height;
    } detection_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_INDEX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic signed [VALUE_W-1:0]    value = '0;
    logic                         frame_start = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [ROW_W-1:0]             row_number;
    logic [CLASS_W-1:0]           class_index;
    logic signed [VALUE_W-1:0]    score;
    logic signed [BOX_W-1:0]      box_left;
    logic signed [BOX_W-1:0]      box_top;
    logic signed [BOX_W-1:0]      box_width;
    logic signed [BOX_W-1:0]      box_height;

    detection_row_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_number  (row_number),
        .class_index (class_index),
        .score       (score),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_width   (box_width),
        .box_height  (box_height)
    );

    // register copy
    logic               cfg_layout = 1'b0;
    logic [POS_W-1:0]   cfg_class_count = 8'd80;
    logic [THR_W-1:0]   cfg_score_thr = 17'd29491;
    logic [THR_W-1:0]   cfg_conf_thr = 17'd16384;
    logic [SCALE_W-1:0] cfg_x_scale = 16'd256;
    logic [SCALE_W-1:0] cfg_y_scale = 16'd256;

    // decoder state
    logic [POS_W-1:0]          elem_pos = '0;
    logic [ROW_W-1:0]          row_index = '0;
    logic signed [VALUE_W-1:0] box_value [BOX_FIELDS];
    logic signed [VALUE_W-1:0] objectness_value = '0;
    logic signed [VALUE_W-1:0] best_value = '0;
    logic [CLASS_W-1:0]        best_index = '0;

    element_t   element_queue [$];
    detection_t expected_detections [$];

    int elements_queued = 0;
    int elements_accepted = 0;
    int results_seen = 0;
    int mismatches = 0;
    int settings_applied = 0;
    int send_idle_pct = 18;
    int take_idle_pct = 56;
    int hold_left = 0;
    int next_hold_at = 30;
    int holds_done = 0;
    int quiet_cycles = 0;

    initial
    begin
        for (int i = 0; i < BOX_FIELDS; i++)
        begin
            box_value[i] = '0;
        end
    end

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int effective_classes(logic [POS_W-1:0] c);
        int n;
        n = c;
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_CLASSES)
        begin
            n = MAX_CLASSES;
        end
        return n;
    endfunction

    // exact product, truncated toward zero, clamped to the box range
    function automatic logic signed [BOX_W-1:0] scale_to_pixels(longint num, longint scale,
                                                                 int shift);
        longint q;
        q = (num * scale) / (longint'(1) << shift);
        if (q > 64'sd8388607)
        begin
            q = 64'sd8388607;
        end
        else if (q < -64'sd8388608)
        begin
            q = -64'sd8388608;
        end
        return q[BOX_W-1:0];
    endfunction

    function automatic void decode_element(logic signed [VALUE_W-1:0] v, logic fs);
        int         count;
        int         first_pos;
        int         last_pos;
        int         p;
        int         k;
        longint     best_wide;
        longint     obj_wide;
        logic       passed;
        detection_t d;
        count = effective_classes(cfg_class_count);
        first_pos = cfg_layout ? FIRST_CLASS_OBJ : FIRST_CLASS_BOX;
        last_pos = first_pos + count - 1;
        if (fs)
        begin
            elem_pos = '0;
            row_index = '0;
        end
        p = elem_pos;
        if (p < BOX_FIELDS)
        begin
            box_value[p] = v;
        end
        else if (p < first_pos)
        begin
            objectness_value = v;
        end
        else
        begin
            k = p - first_pos;
            if (k > count - 1)
            begin
                k = count - 1;
            end
            if (p == first_pos || v > best_value)
            begin
                best_value = v;
                best_index = k[CLASS_W-1:0];
            end
        end
        if (p < last_pos)
        begin
            elem_pos = POS_W'(p + 1);
        end
        else
        begin
            elem_pos = '0;
            best_wide = best_value;
            obj_wide = objectness_value;
            passed = best_wide > longint'(cfg_score_thr);
            if (cfg_layout && obj_wide < longint'(cfg_conf_thr))
            begin
                passed = 1'b0;
            end
            if (passed)
            begin
                d.row = row_index;
                d.cls = best_index;
                d.score = cfg_layout ? objectness_value : best_value;
                d.left = scale_to_pixels(2 * longint'(box_value[0]) - longint'(box_value[2]),
                                         cfg_x_scale, FRAC_W + SCALE_FRAC_W + 1);
                d.top_edge = scale_to_pixels(2 * longint'(box_value[1]) - longint'(box_value[3]),
                                             cfg_y_scale, FRAC_W + SCALE_FRAC_W + 1);
                d.width = scale_to_pixels(box_value[2], cfg_x_scale, FRAC_W + SCALE_FRAC_W);
                d.height = scale_to_pixels(box_value[3], cfg_y_scale, FRAC_W + SCALE_FRAC_W);
                expected_detections.insert(expected_detections.size(), d);
            end
            row_index = row_index + ROW_W'(1);
        end
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // input driver
    always @(posedge clk)
    begin : drive_elements
        element_t next_item;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                decode_element(value, frame_start);
                elements_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (element_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = element_queue.pop_front();
                    in_valid <= 1'b1;
                    value <= next_item.value;
                    frame_start <= next_item.frame_start;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver
    always @(posedge clk)
    begin : take_detections
        detection_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_detections.size() == 0)
                begin
                    $error("unexpected detection for row %0d", row_number);
                    mismatches++;
                end
                else
                begin
                    want = expected_detections.pop_front();
                    check_field("row_number", want.row, row_number);
                    check_field("class_index", want.cls, class_index);
                    check_field("score", want.score, score);
                    check_field("box_left", want.left, box_left);
                    check_field("box_top", want.top_edge, box_top);
                    check_field("box_width", want.width, box_width);
                    check_field("box_height", want.height, box_height);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (results_seen >= next_hold_at)
            begin
                // long back-pressure so the internal queue fills
                hold_left = HOLD_CYCLES;
                next_hold_at = results_seen + 300;
                holds_done++;
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= take_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("detection_row_decoder_tb failed");
            $finish;
        end
    end

    task automatic queue_element(logic signed [VALUE_W-1:0] v, logic fs);
        element_t e;
        e.value = v;
        e.frame_start = fs;
        element_queue.insert(element_queue.size(), e);
        elements_queued++;
    endtask

    task automatic wait_idle();
        do
        begin
            do @(posedge clk);
            while (elements_accepted != elements_queued || expected_detections.size() != 0);
            repeat (6) @(posedge clk);
        end
        while (elements_accepted != elements_queued || expected_detections.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_LAYOUT_MODE:    cfg_layout = data[0];
            REG_CLASS_COUNT:    cfg_class_count = data[POS_W-1:0];
            REG_SCORE_THR:      cfg_score_thr = data[THR_W-1:0];
            REG_CONFIDENCE_THR: cfg_conf_thr = data[THR_W-1:0];
            REG_X_SCALE:        cfg_x_scale = data[SCALE_W-1:0];
            REG_Y_SCALE:        cfg_y_scale = data[SCALE_W-1:0];
            default:            ;
        endcase
    endtask

    task automatic set_config(logic mode, logic [POS_W-1:0] count, logic [THR_W-1:0] sthr,
                              logic [THR_W-1:0] cthr, logic [SCALE_W-1:0] xs,
                              logic [SCALE_W-1:0] ys);
        write_reg(REG_LAYOUT_MODE, CFG_DATA_W'(mode));
        write_reg(REG_CLASS_COUNT, CFG_DATA_W'(count));
        write_reg(REG_SCORE_THR, sthr);
        write_reg(REG_CONFIDENCE_THR, cthr);
        write_reg(REG_X_SCALE, CFG_DATA_W'(xs));
        write_reg(REG_Y_SCALE, CFG_DATA_W'(ys));
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic signed [VALUE_W-1:0] random_coord();
        if ($urandom_range(7) == 0)
        begin
            return $urandom;
        end
        return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_level(logic [THR_W-1:0] thr);
        case ($urandom_range(15))
            0:       return $urandom;
            1:       return int'(thr);
            2:       return int'(thr) + 1;
            default: return int'(thr) + int'($urandom_range(12000)) - 8000;
        endcase
    endfunction

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(3))
            0:       return '0;
            1:       return 17'd65536;
            default: return THR_W'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(3))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'd256;
            default: return SCALE_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // one row for the current registers, sometimes cut short
    task automatic queue_row(logic fs, output logic broken);
        int                        first_pos;
        int                        row_len;
        int                        cut;
        logic signed [VALUE_W-1:0] s;
        logic signed [VALUE_W-1:0] prev;
        first_pos = cfg_layout ? FIRST_CLASS_OBJ : FIRST_CLASS_BOX;
        row_len = first_pos + effective_classes(cfg_class_count);
        cut = ($urandom_range(15) == 0) ? $urandom_range(1, row_len - 1) : row_len;
        prev = '0;
        for (int j = 0; j < cut; j++)
        begin
            if (j < BOX_FIELDS)
            begin
                s = random_coord();
            end
            else if (j < first_pos)
            begin
                s = random_level(cfg_conf_thr);
            end
            else if (j > first_pos && $urandom_range(7) == 0)
            begin
                s = prev;
            end
            else
            begin
                s = random_level(cfg_score_thr);
            end
            queue_element(s, fs && j == 0);
            prev = s;
        end
        broken = cut < row_len;
    endtask

    initial
    begin : run_test
        int               start;
        logic             fs;
        logic             broken;
        logic [POS_W-1:0] cnt;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults, tie between two classes
        queue_element(100 << 16, 1'b1);
        queue_element(50 << 16, 1'b0);
        queue_element(20 << 16, 1'b0);
        queue_element(-(10 << 16), 1'b0);
        for (int j = 0; j < 80; j++)
        begin
            queue_element((j == 37 || j == 60) ? 32'h0001_0000 : 32'd29491, 1'b0);
        end
        wait_idle();

        // saturating boxes, objectness exactly at threshold, rejects
        set_config(1'b1, 8'd2, 17'd0, 17'd65536, 16'hFFFF, 16'd0);
        queue_element(32'h7FFF_FFFF, 1'b0);
        queue_element(32'h8000_0000, 1'b0);
        queue_element(32'h8000_0000, 1'b0);
        queue_element(32'h7FFF_FFFF, 1'b0);
        queue_element(32'h0001_0000, 1'b0);
        queue_element(5, 1'b0);
        queue_element(5, 1'b0);
        queue_element(1, 1'b0);
        queue_element(2, 1'b0);
        queue_element(3, 1'b0);
        queue_element(4, 1'b0);
        queue_element(32'h0000_FFFF, 1'b0);
        queue_element(1, 1'b0);
        queue_element(2, 1'b0);
        queue_element(-1, 1'b0);
        queue_element(0, 1'b0);
        queue_element(32'h0001_0000, 1'b0);
        queue_element(-5, 1'b0);
        queue_element(32'h7FFF_FFFF, 1'b0);
        queue_element(0, 1'b0);
        queue_element(32'h8000_0000, 1'b0);

        // registers change partway through a row; zero class count
        queue_element(32'h0040_0000, 1'b0);
        queue_element(32'h0030_0000, 1'b0);
        queue_element(32'h0010_0000, 1'b0);
        queue_element(32'h0008_0000, 1'b0);
        queue_element(32'h0002_0000, 1'b0);
        wait_idle();
        set_config(1'b0, 8'd0, 17'd65536, 17'd0, 16'd256, 16'd256);
        queue_element(32'h0001_0001, 1'b0);
        wait_idle();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 18;
                    take_idle_pct = 56;
                end
                1:
                begin
                    send_idle_pct = 56;
                    take_idle_pct = 18;
                end
                default:
                begin
                    send_idle_pct = 0;
                    take_idle_pct = 0;
                end
            endcase
            for (int s = 0; s < 4; s++)
            begin
                case ($urandom_range(7))
                    0:       cnt = 8'd0;
                    1:       cnt = 8'd128;
                    2:       cnt = POS_W'($urandom_range(129, 255));
                    default: cnt = POS_W'($urandom_range(1, 6));
                endcase
                set_config(1'($urandom_range(1)), cnt, pick_threshold(), pick_threshold(),
                           pick_scale(), pick_scale());
                start = elements_queued;
                fs = 1'($urandom_range(1));
                while (elements_queued - start < 150)
                begin
                    queue_row(fs, broken);
                    fs = broken || ($urandom_range(9) == 0);
                end
                wait_idle();
            end
        end

        repeat (8) @(posedge clk);
        $display("covered %0d element transfers under %0d register settings, %0d detections",
                 elements_accepted, settings_applied, results_seen);
        $display("idle mixes 18/56, 56/18 and none, %0d long output holds", holds_done);
        if (mismatches == 0)
        begin
            $display("detection_row_decoder_tb passed");
        end
        else
        begin
            $display("detection_row_decoder_tb failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
+incdir+sv
sv/drd_pkg.sv
sv/drd_front.sv
sv/drd_queue.sv
sv/drd_back.sv
sv/detection_row_decoder.sv
tb/detection_row_decoder_tb.sv
